// File: hdl/dmxrx_pkg.sv
// shared types, codes and constants of the dmx512 / rdm frame receiver
package dmxrx_pkg;

  localparam int UNIVERSE_SLOTS_DEF   = 512;
  localparam int RDM_BUFFER_BYTES_DEF = 512;
  localparam int RDM_RING_DEPTH_DEF   = 16;

  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int TARGET_W = 2;
  localparam int BUF_W    = 4;
  localparam int OFFSET_W = 9;
  localparam int EVENT_W  = 3;
  localparam int SLOTS_W  = 10;
  localparam int COUNT_W  = 32;
  localparam int SUM_W    = 16;
  localparam int DCNT_W   = 4;

  // operation codes
  localparam logic [OP_W-1:0] OP_DATA    = 2'd0;
  localparam logic [OP_W-1:0] OP_BREAK   = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  // write targets
  localparam logic [TARGET_W-1:0] TGT_NONE = 2'd0;
  localparam logic [TARGET_W-1:0] TGT_DMX  = 2'd1;
  localparam logic [TARGET_W-1:0] TGT_RDM  = 2'd2;

  // frame events
  localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
  localparam logic [EVENT_W-1:0] EV_DMX_DONE = 3'd1;
  localparam logic [EVENT_W-1:0] EV_RDM_ACC  = 3'd2;
  localparam logic [EVENT_W-1:0] EV_RDM_REJ  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_DISC     = 3'd4;
  localparam logic [EVENT_W-1:0] EV_OVERFLOW = 3'd5;

  // byte codes
  localparam logic [BYTE_W-1:0] SC_DMX        = 8'h00;
  localparam logic [BYTE_W-1:0] SC_RDM        = 8'hCC;
  localparam logic [BYTE_W-1:0] SUB_SC_RDM    = 8'h01;
  localparam logic [BYTE_W-1:0] DISC_PREAMBLE = 8'hFE;
  localparam logic [BYTE_W-1:0] DISC_SEP      = 8'hAA;

  localparam logic [DCNT_W-1:0] EUID_BYTES    = 4'd12;
  localparam logic [DCNT_W-1:0] DISC_CS_BYTES = 4'd4;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] data;
  } in_item_t;

  typedef struct packed {
    logic [TARGET_W-1:0] write_target;
    logic [BUF_W-1:0]    write_buffer;
    logic [OFFSET_W-1:0] write_offset;
    logic [BYTE_W-1:0]   write_data;
    logic [EVENT_W-1:0]  frame_event;
    logic [SLOTS_W-1:0]  slots_in_packet;
    logic [BUF_W-1:0]    buffer_head;
    logic [COUNT_W-1:0]  dmx_starts;
    logic [COUNT_W-1:0]  rdm_starts;
  } result_t;

endpackage

// File: hdl/dmxrx_in_if.sv
// input item channel: uart events
interface dmxrx_in_if
  import dmxrx_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] data;

  modport source (output valid, output operation, output data, input ready);
  modport sink (input valid, input operation, input data, output ready);
endinterface

// File: hdl/dmxrx_out_if.sv
// result item channel: store writes, events and counters
interface dmxrx_out_if
  import dmxrx_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [TARGET_W-1:0] write_target;
  logic [BUF_W-1:0]    write_buffer;
  logic [OFFSET_W-1:0] write_offset;
  logic [BYTE_W-1:0]   write_data;
  logic [EVENT_W-1:0]  frame_event;
  logic [SLOTS_W-1:0]  slots_in_packet;
  logic [BUF_W-1:0]    buffer_head;
  logic [COUNT_W-1:0]  dmx_starts;
  logic [COUNT_W-1:0]  rdm_starts;

  modport source (
    output valid, output write_target, output write_buffer, output write_offset,
    output write_data, output frame_event, output slots_in_packet,
    output buffer_head, output dmx_starts, output rdm_starts, input ready
  );
  modport sink (
    input valid, input write_target, input write_buffer, input write_offset,
    input write_data, input frame_event, input slots_in_packet,
    input buffer_head, input dmx_starts, input rdm_starts, output ready
  );
endinterface

// File: hdl/dmxrx_cfg_if.sv
// configuration write channel: discovery enable
interface dmxrx_cfg_if;
  logic valid;
  logic ready;
  logic discovery_enable;

  modport source (output valid, output discovery_enable, input ready);
  modport sink (input valid, input discovery_enable, output ready);
endinterface

// File: hdl/dmxrx_in_stage.sv
// input register holding one uart event item
module dmxrx_in_stage
  import dmxrx_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  dmxrx_in_if.sink      in_ch,
  input  logic          advance_i,
  output logic          valid_o,
  output in_item_t      item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     accept;

  assign in_ch.ready = !valid_q || advance_i;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.operation <= in_ch.operation;
      item_q.data      <= in_ch.data;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hdl/dmxrx_core.sv
// frame state machine, checksum, ring head and packet counters
module dmxrx_core
  import dmxrx_pkg::*;
#(
  parameter int UNIVERSE_SLOTS   = UNIVERSE_SLOTS_DEF,
  parameter int RDM_BUFFER_BYTES = RDM_BUFFER_BYTES_DEF,
  parameter int RDM_RING_DEPTH   = RDM_RING_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  in_item_t item_i,
  dmxrx_cfg_if.sink cfg_ch,
  output result_t  res_o
);

  localparam int IDX_MAX = (UNIVERSE_SLOTS + 1 > RDM_BUFFER_BYTES) ?
                           UNIVERSE_SLOTS + 1 : RDM_BUFFER_BYTES;
  localparam int IDX_W   = $clog2(IDX_MAX + 1);
  localparam int HEAD_W  = $clog2(RDM_RING_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE, ST_BREAK, ST_DMX, ST_RDM, ST_CSH, ST_CSL, ST_DFE, ST_DEUID, ST_DCS
  } state_e;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [HEAD_W-1:0]   head_q, head_d;
  logic [BYTE_W-1:0]   len_q, len_d;
  logic [BYTE_W-1:0]   sub_q, sub_d;
  logic [DCNT_W-1:0]   dcnt_q, dcnt_d;
  logic [COUNT_W-1:0]  dmx_cnt_q, dmx_cnt_d;
  logic [COUNT_W-1:0]  rdm_cnt_q, rdm_cnt_d;
  logic [SLOTS_W-1:0]  slots_q, slots_d;
  logic                disc_en_q;

  logic [BYTE_W-1:0]   d;
  logic [IDX_W-1:0]    idx_inc;
  logic [IDX_W-1:0]    idx_dec;
  logic [HEAD_W-1:0]   head_inc;
  logic                rdm_ok;
  logic                rdm_wr;
  logic                dmx_wr;
  logic [IDX_W-1:0]    wr_idx;
  logic [BYTE_W-1:0]   len_new;
  logic [SUM_W-1:0]    sum_fin;
  logic [IDX_W+7:0]    idx_cmp;
  logic [IDX_W+7:0]    len_cmp;
  logic [IDX_W+8:0]    off_wide;
  logic [IDX_W+9:0]    slot_wide;
  logic [HEAD_W+3:0]   head_wide_d;
  logic [HEAD_W+3:0]   head_wide_q;
  logic [EVENT_W-1:0]  event_d;

  assign cfg_ch.ready = 1'b1;

  assign d        = item_i.data;
  assign idx_inc  = idx_q + 1'b1;
  assign idx_dec  = idx_q - 1'b1;
  assign head_inc = (head_q == HEAD_W'(RDM_RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign rdm_ok   = idx_q < IDX_W'(RDM_BUFFER_BYTES);
  assign len_new  = (idx_q == IDX_W'(2)) ? d : len_q;
  assign idx_cmp  = {8'd0, idx_inc};
  assign len_cmp  = {{IDX_W{1'b0}}, len_new};
  assign sum_fin  = sum_q - {8'd0, d};
  assign slot_wide = {10'd0, idx_dec};

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    sum_d     = sum_q;
    head_d    = head_q;
    len_d     = len_q;
    sub_d     = sub_q;
    dcnt_d    = dcnt_q;
    dmx_cnt_d = dmx_cnt_q;
    rdm_cnt_d = rdm_cnt_q;
    slots_d   = slots_q;
    event_d   = EV_NONE;
    rdm_wr    = 1'b0;
    dmx_wr    = 1'b0;
    wr_idx    = idx_q;

    case (item_i.operation)
      OP_DATA: begin
        case (state_q)
          ST_IDLE: begin
            if (disc_en_q && d == DISC_PREAMBLE) begin
              state_d = ST_DFE;
              wr_idx  = '0;
              rdm_wr  = 1'b1;
            end
          end
          ST_BREAK: begin
            if (d == SC_DMX) begin
              state_d   = ST_DMX;
              idx_d     = IDX_W'(1);
              dmx_cnt_d = dmx_cnt_q + 1'b1;
            end else if (d == SC_RDM) begin
              state_d   = ST_RDM;
              sum_d     = {8'd0, SC_RDM};
              len_d     = '0;
              sub_d     = '0;
              rdm_cnt_d = rdm_cnt_q + 1'b1;
              wr_idx    = '0;
              rdm_wr    = 1'b1;
            end else begin
              state_d = ST_IDLE;
            end
          end
          ST_DMX: begin
            dmx_wr = 1'b1;
            idx_d  = idx_inc;
            if (idx_q >= IDX_W'(UNIVERSE_SLOTS)) begin
              state_d = ST_IDLE;
              slots_d = SLOTS_W'(UNIVERSE_SLOTS);
              event_d = EV_DMX_DONE;
            end
          end
          ST_RDM, ST_CSH, ST_CSL, ST_DEUID, ST_DCS: begin
            if (!rdm_ok) begin
              state_d = ST_IDLE;
              event_d = EV_OVERFLOW;
            end else begin
              rdm_wr = 1'b1;
              case (state_q)
                ST_RDM: begin
                  sum_d = sum_q + {8'd0, d};
                  len_d = len_new;
                  if (idx_q == IDX_W'(1)) begin
                    sub_d = d;
                  end
                  if (idx_inc >= IDX_W'(3) && idx_cmp == len_cmp) begin
                    state_d = ST_CSH;
                  end
                end
                ST_CSH: begin
                  sum_d   = sum_q - {d, 8'd0};
                  state_d = ST_CSL;
                end
                ST_CSL: begin
                  sum_d   = sum_fin;
                  state_d = ST_IDLE;
                  if (sum_fin == '0 && sub_q == SUB_SC_RDM) begin
                    head_d  = head_inc;
                    event_d = EV_RDM_ACC;
                  end else begin
                    event_d = EV_RDM_REJ;
                  end
                end
                ST_DEUID: begin
                  dcnt_d = dcnt_q + 1'b1;
                  if (dcnt_d == EUID_BYTES) begin
                    dcnt_d  = '0;
                    state_d = ST_DCS;
                  end
                end
                default: begin
                  dcnt_d = dcnt_q + 1'b1;
                  if (dcnt_d == DISC_CS_BYTES) begin
                    head_d  = head_inc;
                    event_d = EV_DISC;
                    state_d = ST_IDLE;
                  end
                end
              endcase
            end
          end
          ST_DFE: begin
            if (d == DISC_PREAMBLE || d == DISC_SEP) begin
              if (!rdm_ok) begin
                state_d = ST_IDLE;
                event_d = EV_OVERFLOW;
              end else begin
                rdm_wr = 1'b1;
                if (d == DISC_SEP) begin
                  dcnt_d  = '0;
                  state_d = ST_DEUID;
                end
              end
            end else begin
              state_d = ST_IDLE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      OP_BREAK: begin
        state_d = ST_BREAK;
      end
      OP_TIMEOUT: begin
        if (state_q == ST_DMX) begin
          state_d = ST_IDLE;
          slots_d = slot_wide[SLOTS_W-1:0];
          event_d = EV_DMX_DONE;
        end
      end
      default: begin
      end
    endcase

    if (rdm_wr) begin
      idx_d = wr_idx + 1'b1;
    end
  end

  assign off_wide    = {9'd0, (dmx_wr ? idx_dec : wr_idx)};
  assign head_wide_d = {4'd0, head_d};
  assign head_wide_q = {4'd0, head_q};

  always_comb begin
    res_o = '0;
    if (rdm_wr) begin
      res_o.write_target = TGT_RDM;
      res_o.write_buffer = head_wide_q[BUF_W-1:0];
      res_o.write_offset = off_wide[OFFSET_W-1:0];
      res_o.write_data   = d;
    end else if (dmx_wr) begin
      res_o.write_target = TGT_DMX;
      res_o.write_offset = off_wide[OFFSET_W-1:0];
      res_o.write_data   = d;
    end
    res_o.frame_event     = event_d;
    res_o.slots_in_packet = slots_d;
    res_o.buffer_head     = head_wide_d[BUF_W-1:0];
    res_o.dmx_starts      = dmx_cnt_d;
    res_o.rdm_starts      = rdm_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      sum_q     <= '0;
      head_q    <= '0;
      len_q     <= '0;
      sub_q     <= '0;
      dcnt_q    <= '0;
      dmx_cnt_q <= '0;
      rdm_cnt_q <= '0;
      slots_q   <= '0;
      disc_en_q <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        disc_en_q <= cfg_ch.discovery_enable;
      end
      if (en_i) begin
        state_q   <= state_d;
        idx_q     <= idx_d;
        sum_q     <= sum_d;
        head_q    <= head_d;
        len_q     <= len_d;
        sub_q     <= sub_d;
        dcnt_q    <= dcnt_d;
        dmx_cnt_q <= dmx_cnt_d;
        rdm_cnt_q <= rdm_cnt_d;
        slots_q   <= slots_d;
      end
    end
  end

endmodule

// File: hdl/dmxrx_out_stage.sv
// result register driving the output channel
module dmxrx_out_stage
  import dmxrx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  result_t   res_i,
  output logic      free_o,
  dmxrx_out_if.source out_ch
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || out_ch.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ch.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_ch.valid           = valid_q;
  assign out_ch.write_target    = res_q.write_target;
  assign out_ch.write_buffer    = res_q.write_buffer;
  assign out_ch.write_offset    = res_q.write_offset;
  assign out_ch.write_data      = res_q.write_data;
  assign out_ch.frame_event     = res_q.frame_event;
  assign out_ch.slots_in_packet = res_q.slots_in_packet;
  assign out_ch.buffer_head     = res_q.buffer_head;
  assign out_ch.dmx_starts      = res_q.dmx_starts;
  assign out_ch.rdm_starts      = res_q.rdm_starts;

endmodule

// File: hdl/dmx512_rdm_frame_receiver_top.sv
// top level of the dmx512 / rdm frame receiver
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    operation, data
//   out_ch    out   valid/ready    write_*, frame_event, slots, head, counters
//   cfg_ch    in    valid/ready    discovery_enable
//
// one item per cycle sustained while out_ch is ready; an accepted input passes through the
// input register, then the result register; the frame state updates as an item
// moves into the result register
// reset clears all frame state, counters, ring head and discovery enable
// a stalled output holds one result, the input register takes one more item
// cfg_ch is always ready
module dmx512_rdm_frame_receiver_top
  import dmxrx_pkg::*;
#(
  parameter int UNIVERSE_SLOTS   = UNIVERSE_SLOTS_DEF,
  parameter int RDM_BUFFER_BYTES = RDM_BUFFER_BYTES_DEF,
  parameter int RDM_RING_DEPTH   = RDM_RING_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dmxrx_in_if.sink    in_ch,
  dmxrx_out_if.source out_ch,
  dmxrx_cfg_if.sink   cfg_ch
);

  logic     in_valid;
  in_item_t in_item;
  logic     out_free;
  logic     advance;
  result_t  res;

  assign advance = in_valid && out_free;

  dmxrx_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .advance_i (advance),
    .valid_o   (in_valid),
    .item_o    (in_item)
  );

  dmxrx_core #(
    .UNIVERSE_SLOTS   (UNIVERSE_SLOTS),
    .RDM_BUFFER_BYTES (RDM_BUFFER_BYTES),
    .RDM_RING_DEPTH   (RDM_RING_DEPTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_item),
    .cfg_ch (cfg_ch),
    .res_o  (res)
  );

  dmxrx_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance),
    .res_i  (res),
    .free_o (out_free),
    .out_ch (out_ch)
  );

endmodule

// File: hdl/dmxrx_checker.sv
// port level checks of the frame receiver, bound to the top level
module dmxrx_assertions
  import dmxrx_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [TARGET_W-1:0] write_target_i,
  input logic [BUF_W-1:0]    write_buffer_i,
  input logic [OFFSET_W-1:0] write_offset_i,
  input logic [BYTE_W-1:0]   write_data_i,
  input logic [EVENT_W-1:0]  frame_event_i,
  input logic [BUF_W-1:0]    buffer_head_i,
  input logic [COUNT_W-1:0]  dmx_starts_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(write_offset_i)
      && $stable(frame_event_i) && $stable(dmx_starts_i))
    else $error("result changed while stalled");

  // no store means no write payload
  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && write_target_i == TGT_NONE |->
      write_buffer_i == '0 && write_offset_i == '0 && write_data_i == '0)
    else $error("write payload without store");

  // rdm end events come with the last byte written, overflow writes nothing
  a_event_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (frame_event_i == EV_RDM_ACC || frame_event_i == EV_RDM_REJ ||
      frame_event_i == EV_DISC) |-> write_target_i == TGT_RDM)
    else $error("rdm event without buffer write");

  // ring head moves only on an accepted message or discovery response
  a_head_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> !out_valid_i ||
      buffer_head_i == $past(buffer_head_i) ||
      frame_event_i == EV_RDM_ACC || frame_event_i == EV_DISC)
    else $error("ring head moved without acceptance");

  // dmx start count steps by at most one per item
  a_dmx_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> !out_valid_i ||
      dmx_starts_i == $past(dmx_starts_i) ||
      dmx_starts_i == $past(dmx_starts_i) + 32'd1)
    else $error("dmx start count jumped");

endmodule

bind dmx512_rdm_frame_receiver_top dmxrx_assertions u_assertions (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .write_target_i (out_ch.write_target),
  .write_buffer_i (out_ch.write_buffer),
  .write_offset_i (out_ch.write_offset),
  .write_data_i   (out_ch.write_data),
  .frame_event_i  (out_ch.frame_event),
  .buffer_head_i  (out_ch.buffer_head),
  .dmx_starts_i   (out_ch.dmx_starts)
);
